>>> sv/fpff_pkg.sv
package fpff_pkg;

    // Field widths fixed by the item format
    localparam int SIZE_W   = 16;
    localparam int TIME_W   = 32;
    localparam int ID_W     = 3;
    localparam int PIDX_W   = 3;
    localparam int PART_MAX = 5;
    localparam int CFG_IDX_W = 3;

    // Command kinds carried on s_tuser
    localparam logic KIND_SUBMIT = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_E = 3'd4;

    typedef logic [PART_MAX-1:0][SIZE_W-1:0] cap_array_t;

    localparam cap_array_t CAP_RESET = {16'd76, 16'd75, 16'd55, 16'd18, 16'd212};

    typedef enum logic [1:0] {
        ST_FREE   = 2'd0,
        ST_WAIT   = 2'd1,
        ST_ACTIVE = 2'd2
    } slot_status_t;

    typedef enum logic [2:0] {
        EV_QUEUED    = 3'd0,
        EV_REJECT    = 3'd1,
        EV_COMPLETE  = 3'd2,
        EV_ADMIT     = 3'd3,
        EV_TICK_DONE = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_CRD,
        S_CWR,
        S_ARD,
        S_AFIT,
        S_DONE
    } fsm_state_t;

    // One slot memory entry
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] remaining;
        logic [PIDX_W-1:0] part;
    } slot_entry_t;

    // First-fit search result
    typedef struct packed {
        logic              found;
        logic [PIDX_W-1:0] index;
    } fit_t;

endpackage

>>> sv/fixed_partition_first_fit_allocator.sv
// Fixed-partition first-fit job allocator.
// Input stream (s_*): one word per command. s_tuser is the kind (0 submit,
// 1 tick); a submit carries job size and burst length in s_tdata.
// Result stream (m_*): one or more words per command, the final one marked
// by m_tlast. A submit gives one word (queued or rejected). A tick gives
// completions in slot order, then admissions in submission order, then a
// tick-done word; all carry the tick count from before the tick.
// Configuration: cfg_we/cfg_index/cfg_data write the five partition
// capacities; write only while no command is in flight.
// Throughput: one command at a time. A tick scans the slot memory through
// its single read port, one slot per cycle unless a result word is held,
// with an extra countdown step for each active job, then reads and tries
// to place the queued jobs in submission order.
// Reset: all slots free, all partitions idle, pointers and tick count zero,
// capacities back to their defaults. No clearing pass is needed.
// Stall: one output register holds a word until m_tready; a state with a word
// to emit waits in place while it is full, and s_tready drops until the command ends.
module fixed_partition_first_fit_allocator #(
    parameter int JOB_SLOTS       = 8,
    parameter int PARTITION_COUNT = 5
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,  // job_size[15:0], job_burst[31:16]
    input  logic                               s_tuser,  // kind
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [47:0]                        m_tdata,  // event_res[2:0], job_id[5:3],
                                                         // partition_index[8:6],
                                                         // tick_time[40:9], zero pad
    output logic                               m_tlast,
    // configuration
    input  logic                               cfg_we,
    input  logic [fpff_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fpff_pkg::SIZE_W-1:0]        cfg_data
);
    import fpff_pkg::*;

    localparam int SLOT_W  = $clog2(JOB_SLOTS);
    localparam int ENTRY_W = $bits(slot_entry_t);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(JOB_SLOTS - 1);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    fsm_state_t               state_reg, state_next;
    slot_status_t             status_reg [JOB_SLOTS];
    logic [PARTITION_COUNT-1:0] busy_reg;
    logic [SLOT_W-1:0]        admit_ptr_reg, sub_ptr_reg, scan_reg;
    logic [TIME_W-1:0]        tick_reg;
    cap_array_t               cap_reg;
    logic [SIZE_W-1:0]        in_size_reg, in_burst_reg;

    // output register
    logic                     m_valid_reg;
    event_t                   m_event_reg;
    logic [ID_W-1:0]          m_job_reg;
    logic [PIDX_W-1:0]        m_part_reg;
    logic [TIME_W-1:0]        m_time_reg;
    logic                     m_last_reg;

    // control from the sequencer
    logic                     emit, emit_last;
    event_t                   emit_ev;
    logic [SLOT_W-1:0]        emit_slot;
    logic [PIDX_W-1:0]        emit_part;
    logic                     rd_en, wr_en;
    logic [SLOT_W-1:0]        rd_addr, wr_addr;
    slot_entry_t              wr_data, rd_data;
    logic [ENTRY_W-1:0]       rd_bits;
    fit_t                     fit;

    logic                     out_free;
    logic                     in_accept;
    logic                     rem_gt1;
    logic                     last_scan;
    logic [JOB_SLOTS-1:0]     act_vec;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign rd_data   = slot_entry_t'(rd_bits);
    assign rem_gt1   = (rd_data.remaining > SIZE_W'(1));
    assign last_scan = (scan_reg == LAST_SLOT);

    always_comb begin
        for (int i = 0; i < JOB_SLOTS; i++) begin
            act_vec[i] = (status_reg[i] == ST_ACTIVE);
        end
    end

    // ---------------------------------------------------------------
    // Slot memory: size, remaining burst and partition per ring slot
    // ---------------------------------------------------------------
    fpff_slot_ram #(
        .DEPTH (JOB_SLOTS),
        .WIDTH (ENTRY_W)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_bits)
    );

    fpff_fit #(
        .PARTITION_COUNT (PARTITION_COUNT)
    ) u_fit (
        .busy (busy_reg),
        .caps (cap_reg),
        .need (rd_data.size),
        .fit  (fit)
    );

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    state_next = (s_tuser == KIND_TICK) ? S_CRD : S_SUB;
                end
            end
            S_SUB: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_CRD: begin
                if (status_reg[scan_reg] == ST_ACTIVE) begin
                    state_next = S_CWR;
                end else if (last_scan) begin
                    state_next = S_ARD;
                end
            end
            S_CWR: begin
                if (rem_gt1 || out_free) begin
                    state_next = last_scan ? S_ARD : S_CRD;
                end
            end
            S_ARD: begin
                state_next = (status_reg[admit_ptr_reg] == ST_WAIT) ? S_AFIT : S_DONE;
            end
            S_AFIT: begin
                if (!fit.found) begin
                    state_next = S_DONE;
                end else if (out_free) begin
                    state_next = S_ARD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer outputs: memory access and result word
    // ---------------------------------------------------------------
    always_comb begin
        emit      = 1'b0;
        emit_last = 1'b0;
        emit_ev   = EV_QUEUED;
        emit_slot = scan_reg;
        emit_part = '0;
        rd_en     = 1'b0;
        rd_addr   = scan_reg;
        wr_en     = 1'b0;
        wr_addr   = scan_reg;
        wr_data   = rd_data;
        unique case (state_reg)
            S_IDLE: begin
            end
            S_SUB: begin
                emit      = 1'b1;
                emit_last = 1'b1;
                emit_slot = sub_ptr_reg;
                wr_addr   = sub_ptr_reg;
                wr_data.size      = in_size_reg;
                wr_data.remaining = in_burst_reg;
                wr_data.part      = '0;
                if (status_reg[sub_ptr_reg] != ST_FREE) begin
                    emit_ev = EV_REJECT;
                end else begin
                    emit_ev = EV_QUEUED;
                    wr_en   = out_free;
                end
            end
            S_CRD: begin
                rd_en = 1'b1;
            end
            S_CWR: begin
                // count down, or retire the job and report its partition
                if (rem_gt1) begin
                    wr_en             = 1'b1;
                    wr_data.remaining = rd_data.remaining - SIZE_W'(1);
                end else begin
                    emit      = 1'b1;
                    emit_ev   = EV_COMPLETE;
                    emit_part = rd_data.part;
                end
            end
            S_ARD: begin
                rd_en   = 1'b1;
                rd_addr = admit_ptr_reg;
            end
            S_AFIT: begin
                emit_slot = admit_ptr_reg;
                wr_addr   = admit_ptr_reg;
                wr_data.part = fit.index;
                if (fit.found) begin
                    emit      = 1'b1;
                    emit_ev   = EV_ADMIT;
                    emit_part = fit.index;
                    wr_en     = out_free;
                end
            end
            S_DONE: begin
                emit      = 1'b1;
                emit_last = 1'b1;
                emit_ev   = EV_TICK_DONE;
                emit_slot = '0;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            busy_reg      <= '0;
            admit_ptr_reg <= '0;
            sub_ptr_reg   <= '0;
            scan_reg      <= '0;
            tick_reg      <= '0;
            cap_reg       <= CAP_RESET;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < JOB_SLOTS; i++) begin
                status_reg[i] <= ST_FREE;
            end
        end else begin
            state_reg <= state_next;

            // capacities; indexes past the last register drop the write
            if (cfg_we && cfg_index < CFG_IDX_W'(PART_MAX)) begin
                cap_reg[cfg_index] <= cfg_data;
            end

            if (in_accept) begin
                scan_reg <= '0;
            end

            // advance the completion scan
            if ((state_reg == S_CRD && status_reg[scan_reg] != ST_ACTIVE && !last_scan)
                || (state_reg == S_CWR && (rem_gt1 || out_free) && !last_scan)) begin
                scan_reg <= scan_reg + SLOT_W'(1);
            end

            if (state_reg == S_SUB && out_free && status_reg[sub_ptr_reg] == ST_FREE) begin
                status_reg[sub_ptr_reg] <= ST_WAIT;
                sub_ptr_reg <= (sub_ptr_reg == LAST_SLOT) ? '0 : sub_ptr_reg + SLOT_W'(1);
            end

            // retire: free the slot and its partition
            if (state_reg == S_CWR && !rem_gt1 && out_free) begin
                status_reg[scan_reg] <= ST_FREE;
                for (int p = 0; p < PARTITION_COUNT; p++) begin
                    if (rd_data.part == PIDX_W'(p)) begin
                        busy_reg[p] <= 1'b0;
                    end
                end
            end

            // admit: claim the partition and move the head of the queue
            if (state_reg == S_AFIT && fit.found && out_free) begin
                status_reg[admit_ptr_reg] <= ST_ACTIVE;
                for (int p = 0; p < PARTITION_COUNT; p++) begin
                    if (fit.index == PIDX_W'(p)) begin
                        busy_reg[p] <= 1'b1;
                    end
                end
                admit_ptr_reg <= (admit_ptr_reg == LAST_SLOT) ? '0
                                                              : admit_ptr_reg + SLOT_W'(1);
            end

            if (state_reg == S_DONE && out_free) begin
                tick_reg <= tick_reg + TIME_W'(1);
            end

            if (emit && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_size_reg  <= s_tdata[15:0];
            in_burst_reg <= s_tdata[31:16];
        end
        if (emit && out_free) begin
            m_event_reg <= emit_ev;
            m_job_reg   <= ID_W'(emit_slot);
            m_part_reg  <= emit_part;
            m_time_reg  <= tick_reg;
            m_last_reg  <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_time_reg, m_part_reg, m_job_reg, m_event_reg};
    assign m_tlast  = m_last_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // every busy partition belongs to exactly one running job
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(busy_reg) == $countones(act_vec))
        else $error("busy partitions do not match active jobs");

    // the tick count moves only with the tick-done word
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg == S_DONE && out_free) |=> $stable(tick_reg))
        else $error("tick count moved outside tick completion");

    // the submit pointer moves only while a submit is handled
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_SUB |=> $stable(sub_ptr_reg))
        else $error("submit pointer moved outside a submit");

    // read-modify-write only touches running jobs
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CWR |-> status_reg[scan_reg] == ST_ACTIVE)
        else $error("countdown on a slot that is not running");

endmodule

>>> sv/fpff_slot_ram.sv
module fpff_slot_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 35
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/fpff_fit.sv
module fpff_fit #(
    parameter int PARTITION_COUNT = 5
) (
    input  logic [PARTITION_COUNT-1:0]   busy,
    input  fpff_pkg::cap_array_t         caps,
    input  logic [fpff_pkg::SIZE_W-1:0]  need,
    output fpff_pkg::fit_t               fit
);
    import fpff_pkg::*;

    // lowest free partition with enough capacity wins
    always_comb begin
        fit = '0;
        for (int p = PARTITION_COUNT - 1; p >= 0; p--) begin
            if (!busy[p] && caps[p] >= need) begin
                fit.found = 1'b1;
                fit.index = PIDX_W'(p);
            end
        end
    end

endmodule

>>> tb/allocator_event_checker.sv
module allocator_event_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [31:0]                    s_tdata,  // job_size[15:0], job_burst[31:16]
    input  logic                           s_tuser,  // kind
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [47:0]                    m_tdata,  // event_res[2:0], job_id[5:3],
                                                     // partition_index[8:6],
                                                     // tick_time[40:9], zero pad
    input  logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [fpff_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fpff_pkg::SIZE_W-1:0]    cfg_data,
    output int                             mismatch_count,
    output int                             words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fpff_pkg::*;

    localparam int SLOTS = 8;
    localparam int PARTS = 5;

    typedef struct packed {
        event_t            ev;
        logic [ID_W-1:0]   job;
        logic [PIDX_W-1:0] part;
        logic [TIME_W-1:0] stamp;
        logic              last;
    } alloc_event_t;

    alloc_event_t        expected_events[$];

    logic [SIZE_W-1:0]   part_cap  [PARTS];
    logic                part_busy [PARTS];
    logic [SIZE_W-1:0]   job_need  [SLOTS];
    logic [SIZE_W-1:0]   job_left  [SLOTS];
    slot_status_t        job_state [SLOTS];
    logic [PIDX_W-1:0]   job_part  [SLOTS];
    logic [ID_W-1:0]     admit_ptr;
    logic [ID_W-1:0]     submit_ptr;
    logic [TIME_W-1:0]   tick_count;

    task automatic add_event(input event_t ev, input logic [ID_W-1:0] job,
                             input logic [PIDX_W-1:0] part, input logic last);
        alloc_event_t e;
        e.ev    = ev;
        e.job   = job;
        e.part  = part;
        e.stamp = tick_count;
        e.last  = last;
        expected_events.push_back(e);
    endtask

    function automatic int lowest_free_fit(input logic [SIZE_W-1:0] need);
        int found;
        found = -1;
        for (int p = 0; p < PARTS && found < 0; p++) begin
            if (!part_busy[p] && part_cap[p] >= need) found = p;
        end
        return found;
    endfunction

    // Work out every event one command causes and advance the allocator copy.
    task automatic predict_command(input logic kind, input logic [SIZE_W-1:0] need,
                                   input logic [SIZE_W-1:0] burst);
        int spot;
        if (kind != KIND_TICK) begin
            if (job_state[submit_ptr] != ST_FREE) begin
                add_event(EV_REJECT, submit_ptr, '0, 1'b1);
            end else begin
                job_need[submit_ptr]  = need;
                job_left[submit_ptr]  = burst;
                job_state[submit_ptr] = ST_WAIT;
                add_event(EV_QUEUED, submit_ptr, '0, 1'b1);
                submit_ptr = submit_ptr + 1'b1;
            end
            return;
        end
        // count down active jobs in slot order; zero burst finishes like one
        for (int i = 0; i < SLOTS; i++) begin
            if (job_state[i] == ST_ACTIVE) begin
                if (job_left[i] > 1) begin
                    job_left[i] = job_left[i] - 1'b1;
                end else begin
                    job_left[i]  = '0;
                    part_busy[job_part[i]] = 1'b0;
                    job_state[i] = ST_FREE;
                    add_event(EV_COMPLETE, i[ID_W-1:0], job_part[i], 1'b0);
                end
            end
        end
        // admit in submission order, stop at the first job that does not fit
        for (int g = 0; g < SLOTS; g++) begin
            if (job_state[admit_ptr] != ST_WAIT) break;
            spot = lowest_free_fit(job_need[admit_ptr]);
            if (spot < 0) break;
            part_busy[spot]     = 1'b1;
            job_part[admit_ptr] = spot[PIDX_W-1:0];
            job_state[admit_ptr] = ST_ACTIVE;
            add_event(EV_ADMIT, admit_ptr, spot[PIDX_W-1:0], 1'b0);
            admit_ptr = admit_ptr + 1'b1;
        end
        add_event(EV_TICK_DONE, '0, '0, 1'b1);
        tick_count = tick_count + 1'b1;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        alloc_event_t e;
        if (!aresetn) begin
            for (int p = 0; p < PARTS; p++) begin
                part_cap[p]  = CAP_RESET[p];
                part_busy[p] = 1'b0;
            end
            for (int i = 0; i < SLOTS; i++) begin
                job_state[i] = ST_FREE;
                job_need[i]  = '0;
                job_left[i]  = '0;
                job_part[i]  = '0;
            end
            admit_ptr  = '0;
            submit_ptr = '0;
            tick_count = '0;
            expected_events.delete();
        end else begin
            if (cfg_we && cfg_index < PARTS) part_cap[cfg_index] = cfg_data;
            if (s_tvalid && s_tready)
                predict_command(s_tuser, s_tdata[15:0], s_tdata[31:16]);
            if (m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    $error("result word with no event expected: %h", m_tdata);
                    mismatch_count++;
                end else begin
                    e = expected_events.pop_front();
                    check_field("event_res", e.ev, m_tdata[2:0]);
                    check_field("job_id", e.job, m_tdata[5:3]);
                    check_field("partition_index", e.part, m_tdata[8:6]);
                    check_field("tick_time", e.stamp, m_tdata[40:9]);
                    check_field("last", e.last, m_tlast);
                end
            end
        end
        words_pending = expected_events.size();
    end

endmodule

>>> tb/tb_fixed_partition_first_fit_allocator.sv
module tb_fixed_partition_first_fit_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import fpff_pkg::*;

    // indexes past the last partition; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int SETTLE_CYCLES = 40;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;  // job_size[15:0], job_burst[31:16]
    logic                 s_tuser   = 1'b0; // kind
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [47:0]          m_tdata;         // event_res[2:0], job_id[5:3],
                                           // partition_index[8:6], tick_time[40:9]
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]    cfg_data  = '0;

    int mismatch_count;
    int words_pending;

    // stretches where neither side idles
    bit quiet_run = 1'b0;
    // capacities currently programmed, used only to shape job sizes
    int cap_now[5] = '{212, 18, 55, 75, 76};

    always #1 aclk = ~aclk;

    fixed_partition_first_fit_allocator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    allocator_event_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    // Offer one command word: idle a random gap, then hold valid until taken.
    // Valid stays high into the next word when the next gap is zero.
    task automatic send_command(input logic kind, input logic [15:0] job_size,
                                input logic [15:0] job_burst);
        int unsigned gap;
        gap = quiet_run ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {job_burst, job_size};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid, wait for every expected word, then let the block settle.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    task automatic set_capacities(input int a, input int b, input int c, input int d,
                                  input int e);
        write_reg(CFG_SIZE_A, a[15:0]);
        write_reg(CFG_SIZE_B, b[15:0]);
        write_reg(CFG_SIZE_C, c[15:0]);
        write_reg(CFG_SIZE_D, d[15:0]);
        write_reg(CFG_SIZE_E, e[15:0]);
        cfg_we <= 1'b0;
        cap_now = '{a, b, c, d, e};
    endtask

    // Random traffic: ticks mixed with submits whose sizes mostly fit the
    // largest partition. Rare oversize jobs block the queue until a later
    // setting lets them in. Long bursts only where wide_bursts is set,
    // since each one holds a partition for the rest of the run.
    task automatic run_phase(input int count, input bit wide_bursts);
        int maxcap;
        int need;
        int burst;
        maxcap = 0;
        foreach (cap_now[p]) if (cap_now[p] > maxcap) maxcap = cap_now[p];
        for (int k = 0; k < count; k++) begin
            quiet_run = ((k / 16) % 4) == 3;
            if ($urandom_range(0, 99) < 45) begin
                // tick fields carry noise; the block must ignore them
                send_command(KIND_TICK, 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)));
            end else begin
                if ($urandom_range(0, 24) == 0 && maxcap < 65535)
                    need = $urandom_range(maxcap + 1, 65535);
                else
                    need = $urandom_range(0, maxcap);
                if (wide_bursts && $urandom_range(0, 4) == 0)
                    burst = $urandom_range(1, 65535);
                else
                    burst = $urandom_range(1, 4);
                send_command(KIND_SUBMIT, need[15:0], burst[15:0]);
            end
        end
        quiet_run = 1'b0;
    endtask

    // Ready side: stall a random number of cycles before each result word.
    initial begin : result_sink
        int unsigned hold;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            hold = quiet_run ? 0 : $urandom_range(0, 17);
            if (hold != 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset capacities 212/18/55/75/76.
        // Tick with nothing queued: only tick done at time zero.
        send_command(KIND_TICK, 16'h0000, 16'h0000);
        // Zero size with zero burst: fits partition a, finishes after one tick.
        send_command(KIND_SUBMIT, 16'd0, 16'd0);
        // Exact fits; 212 must wait behind the zero-size job on partition a.
        send_command(KIND_SUBMIT, 16'd212, 16'd1);
        send_command(KIND_SUBMIT, 16'd18, 16'd2);
        send_command(KIND_SUBMIT, 16'd76, 16'd3);
        send_command(KIND_SUBMIT, 16'd75, 16'd1);
        send_command(KIND_SUBMIT, 16'd55, 16'd2);
        // Fill the ring; 300 fits nowhere and stalls admission behind it.
        send_command(KIND_SUBMIT, 16'd300, 16'd1);
        send_command(KIND_SUBMIT, 16'd1, 16'd1);
        // Ring full: rejected, pointer holds.
        send_command(KIND_SUBMIT, 16'd5, 16'd5);
        // Admit the first job, then free a and admit the five exact fits.
        send_command(KIND_TICK, 16'hFFFF, 16'hFFFF);
        send_command(KIND_TICK, 16'h5A5A, 16'hA5A5);
        send_command(KIND_TICK, 16'd0, 16'd0);
        send_command(KIND_TICK, 16'hFFFF, 16'h0000);
        send_command(KIND_SUBMIT, 16'd10, 16'd1);
        send_command(KIND_TICK, 16'd0, 16'hFFFF);
        drain();

        // Dropped writes to indexes past the last partition.
        write_reg(CFG_SPARE_LO, 16'h0000);
        write_reg(CFG_SPARE_HI, 16'hFFFF);
        // Extremes: huge, empty, one unit, half range, modest.
        set_capacities(65535, 0, 1, 32768, 100);
        run_phase(50, 1'b0);
        drain();

        set_capacities($urandom_range(0, 300), $urandom_range(0, 300),
                       $urandom_range(0, 300), $urandom_range(0, 300),
                       $urandom_range(0, 300));
        run_phase(60, 1'b0);
        drain();

        // Every partition empty: only zero-size jobs get in.
        set_capacities(0, 0, 0, 0, 0);
        run_phase(20, 1'b0);
        drain();

        set_capacities($urandom_range(0, 400), $urandom_range(0, 400),
                       $urandom_range(0, 400), $urandom_range(0, 400),
                       $urandom_range(0, 400));
        run_phase(60, 1'b0);
        drain();

        // Everything fits; full-range sizes and long bursts.
        set_capacities(65535, 65535, 65535, 65535, 65535);
        run_phase(80, 1'b1);
        drain();

        if (mismatch_count == 0 && words_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #1000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
sv/fpff_pkg.sv
sv/fpff_slot_ram.sv
sv/fpff_fit.sv
sv/fixed_partition_first_fit_allocator.sv
tb/allocator_event_checker.sv
tb/tb_fixed_partition_first_fit_allocator.sv
